@@ rtl/header_length_frame_deframer_unit_macros.svh @@
`ifndef HEADER_LENGTH_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define HEADER_LENGTH_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define HLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hlfd check failed");

// next-cycle implication
`define HLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hlfd check failed");

`endif

@@ rtl/hlfd_pkg.sv @@
package hlfd_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h55;
  localparam logic [POS_W-1:0]  LEN_POS    = 6'd2;
  localparam logic [POS_W-1:0]  CLOSE_POS  = 6'd3;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic             push;
    logic [POS_W-1:0] last_pos;
  } frame_desc_t;

endpackage

@@ rtl/hlfd_front.sv @@
module hlfd_front #(
  parameter int MAX_POSITION = 51
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rx_valid_i,
  input  logic                           hold_i,
  input  logic [hlfd_pkg::BYTE_W-1:0]    rx_byte_i,
  output hlfd_pkg::wr_t                  wr_o,
  output hlfd_pkg::frame_desc_t          desc_o
);

  logic [hlfd_pkg::BYTE_W-1:0] prev_q, prev_d;
  logic [hlfd_pkg::POS_W-1:0]  position_q, position_d;
  logic                        in_frame_q, in_frame_d;
  logic [hlfd_pkg::BYTE_W-1:0] remaining_q, remaining_d;
  logic [hlfd_pkg::POS_W:0]    pos_n;
  logic                        accept;

  assign accept = rx_valid_i && !hold_i;

  always_comb begin
    prev_d      = prev_q;
    position_d  = position_q;
    in_frame_d  = in_frame_q;
    remaining_d = remaining_q;
    wr_o        = '0;
    desc_o      = '0;
    pos_n       = {1'b0, position_q};
    if (accept) begin
      if (rx_byte_i == hlfd_pkg::HDR_SECOND && !in_frame_q) begin
        if (prev_q == hlfd_pkg::HDR_FIRST) begin
          pos_n      = (hlfd_pkg::POS_W+1)'(1);
          in_frame_d = 1'b1;
        end
      end else begin
        prev_d = rx_byte_i;
        if (in_frame_q) begin
          if (position_q == hlfd_pkg::LEN_POS) begin
            remaining_d = rx_byte_i;
          end else if (position_q > hlfd_pkg::LEN_POS) begin
            remaining_d = remaining_q - 8'd1;
          end
          wr_o.en   = 1'b1;
          wr_o.addr = position_q;
          wr_o.data = rx_byte_i;
        end
      end
      pos_n = pos_n + (hlfd_pkg::POS_W+1)'(1);
      if (pos_n > (hlfd_pkg::POS_W+1)'(MAX_POSITION)) begin
        pos_n      = '0;
        in_frame_d = 1'b0;
      end
      if (in_frame_d && remaining_d == '0 && pos_n > {1'b0, hlfd_pkg::CLOSE_POS}) begin
        in_frame_d      = 1'b0;
        desc_o.push     = 1'b1;
        desc_o.last_pos = pos_n[hlfd_pkg::POS_W-1:0] - 6'd1;
        pos_n           = '0;
      end
      position_d = pos_n[hlfd_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      position_q  <= '0;
      in_frame_q  <= 1'b0;
      remaining_q <= '0;
    end else begin
      prev_q      <= prev_d;
      position_q  <= position_d;
      in_frame_q  <= in_frame_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

@@ rtl/hlfd_queue.sv @@
module hlfd_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [hlfd_pkg::POS_W-1:0]   data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output logic [hlfd_pkg::POS_W-1:0]   data_o
);

  logic [hlfd_pkg::POS_W-1:0] entry_q [2];
  logic                       wptr_q, wptr_d;
  logic                       rptr_q, rptr_d;
  logic [1:0]                 count_q, count_d;
  logic                       do_push;
  logic                       do_pop;

  assign valid_o = count_q != 2'd0;
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && count_q != 2'd2;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? ~wptr_q : wptr_q;
    rptr_d  = do_pop ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/hlfd_back.sv @@
module hlfd_back #(
  parameter int MAX_POSITION = 51
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hlfd_pkg::wr_t                wr_i,
  input  logic                         q_valid_i,
  input  logic [hlfd_pkg::POS_W-1:0]   q_last_pos_i,
  output logic                         q_pop_o,
  output logic                         busy_o,
  output logic                         frame_valid_o,
  input  logic                         frame_stall_i,
  output logic [hlfd_pkg::BYTE_W-1:0]  frame_byte_o,
  output logic [hlfd_pkg::POS_W-1:0]   frame_position_o,
  output logic                         last_o
);

  localparam int Depth = MAX_POSITION + 1;
  localparam int AW    = $clog2(Depth);

  logic [hlfd_pkg::BYTE_W-1:0] store_q [Depth];
  logic [hlfd_pkg::BYTE_W-1:0] rd_data_q;
  logic                        busy_q, busy_d;
  logic                        pend_q, pend_d;
  logic [hlfd_pkg::POS_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [hlfd_pkg::POS_W-1:0]  end_q, end_d;
  logic                        out_valid_q, out_valid_d;
  logic [hlfd_pkg::POS_W-1:0]  out_pos_q, out_pos_d;
  logic                        out_last_q, out_last_d;
  logic                        take;
  logic                        issue;

  assign take    = out_valid_q && !frame_stall_i;
  assign issue   = busy_q && !pend_q && (!out_valid_q || take);
  assign q_pop_o = q_valid_i && !busy_q;
  assign busy_o  = busy_q;

  assign frame_valid_o    = out_valid_q;
  assign frame_byte_o     = rd_data_q;
  assign frame_position_o = out_pos_q;
  assign last_o           = out_last_q;

  always_comb begin
    busy_d      = busy_q;
    rd_ptr_d    = rd_ptr_q;
    end_d       = end_q;
    pend_d      = issue;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
    end else if (take) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      busy_d   = 1'b1;
      rd_ptr_d = hlfd_pkg::LEN_POS;
      end_d    = q_last_pos_i;
    end else if (issue) begin
      out_pos_d  = rd_ptr_q;
      out_last_d = rd_ptr_q == end_q;
      rd_ptr_d   = rd_ptr_q + 6'd1;
      if (rd_ptr_q == end_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= store_q[rd_ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    end_q      <= end_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/header_length_frame_deframer_unit.sv @@
// channel | direction | handshake                  | payload
// rx      | in        | rx_valid_i / rx_stall_o    | rx_byte_i
// frame   | out       | frame_valid_o / frame_stall_i | frame_byte_o, frame_position_o, last_o
// a byte is taken when rx_valid_i is high and rx_stall_o is low; a closing byte queues the frame for readout
// readout issues one store read at a time; each emitted item waits for its registered store read
// input stalls from frame close until the last item has been read from the store
// rst_ni clears framing state, queue and readout control; the store is not cleared
// a stalled output holds its item and the store read waits behind it

`include "header_length_frame_deframer_unit_macros.svh"

module header_length_frame_deframer_unit #(
  parameter int MAX_POSITION = 51
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rx_valid_i,
  output logic                         rx_stall_o,
  input  logic [hlfd_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                         frame_valid_o,
  input  logic                         frame_stall_i,
  output logic [hlfd_pkg::BYTE_W-1:0]  frame_byte_o,
  output logic [hlfd_pkg::POS_W-1:0]   frame_position_o,
  output logic                         last_o
);

  hlfd_pkg::wr_t              wr;
  hlfd_pkg::frame_desc_t      desc;
  logic                       q_valid;
  logic [hlfd_pkg::POS_W-1:0] q_last_pos;
  logic                       q_pop;
  logic                       bk_busy;

  assign rx_stall_o = q_valid || bk_busy;

  hlfd_front #(
    .MAX_POSITION(MAX_POSITION)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(rx_valid_i),
    .hold_i    (rx_stall_o),
    .rx_byte_i (rx_byte_i),
    .wr_o      (wr),
    .desc_o    (desc)
  );

  hlfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (desc.push),
    .data_i (desc.last_pos),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_last_pos)
  );

  hlfd_back #(
    .MAX_POSITION(MAX_POSITION)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .q_valid_i       (q_valid),
    .q_last_pos_i    (q_last_pos),
    .q_pop_o         (q_pop),
    .busy_o          (bk_busy),
    .frame_valid_o   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_byte_o    (frame_byte_o),
    .frame_position_o(frame_position_o),
    .last_o          (last_o)
  );

  `HLFD_ASSERT_NOW(a_no_write_during_readout, clk_i, rst_ni, wr.en, !bk_busy)
  `HLFD_ASSERT_NOW(a_single_pending_frame, clk_i, rst_ni, desc.push, !q_valid && !bk_busy)
  `HLFD_ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni,
                    frame_valid_o && !frame_stall_i && last_o, !frame_valid_o)
  `HLFD_ASSERT_NOW(a_position_floor, clk_i, rst_ni, frame_valid_o,
                   frame_position_o >= hlfd_pkg::LEN_POS)

endmodule
